### rtl/rdt_pkg.sv
// rdt_pkg: shared types, constants and helpers of the reminder day table
// depends on nothing; used by every module of the block

package rdt_pkg;

  localparam int TABLE_DEPTH_DEF = 16;
  localparam int MSG_ID_BITS_DEF = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int HIT_W           = $clog2(MAX_RESULTS + 1);

  localparam int MONTHS_PER_YEAR = 12;
  localparam logic [4:0] DAYS_FEB   = 5'd28;
  localparam logic [4:0] DAYS_SHORT = 5'd30;
  localparam logic [4:0] DAYS_LONG  = 5'd31;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  typedef enum logic [1:0] {
    OP_ADD  = 2'd0,
    OP_ADV  = 2'd1,
    OP_LIST = 2'd2
  } rdt_op_e;

  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_LISTED = 2'd2,
    ST_NOHIT  = 2'd3
  } rdt_status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_MONTH = 1'b0,
    CFG_START_DAY   = 1'b1
  } rdt_cfg_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_READ,
    S_CHECK,
    S_FINISH
  } rdt_state_e;

  typedef enum logic [2:0] {
    OSEL_OFF,
    OSEL_DONE,
    OSEL_FULL,
    OSEL_NOHIT,
    OSEL_HIT,
    OSEL_HIT_LAST
  } rdt_osel_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  rem_month;
    logic [4:0]  rem_day;
    logic [4:0]  rem_hour;
    logic [5:0]  rem_minute;
    logic [15:0] rem_msg_id;
  } rdt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  cur_month;
    logic [4:0]  cur_day;
    logic [3:0]  out_month;
    logic [4:0]  out_day;
    logic [4:0]  out_hour;
    logic [5:0]  out_minute;
    logic [15:0] out_msg_id;
    logic        last;
  } rdt_out_t;

  typedef struct packed {
    logic      add_en;
    logic      adv_en;
    logic      scan_start;
    logic      rd_en;
    logic      take_hit;
    logic      idx_inc;
    rdt_osel_e osel;
  } rdt_cmd_t;

  typedef struct packed {
    logic out_free;
    logic full;
    logic cnt_zero;
    logic hit;
    logic hits_cap;
    logic scan_last;
    logic pend_vld;
  } rdt_sts_t;

  // month length, non-leap; months out of range count as long
  function automatic logic [4:0] days_of(input logic [3:0] month);
    logic [4:0] len;
    case (month) inside
      4'd2:                     len = DAYS_FEB;
      4'd4, 4'd6, 4'd9, 4'd11:  len = DAYS_SHORT;
      default:                  len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

### rtl/rdt_ctrl.sv
// rdt_ctrl: state machine sequencing add, advance and the listing scan
// depends on rdt_pkg; drives the datapath rdt_dp through command/status structs

module rdt_ctrl import rdt_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic [1:0] in_op_i,
  input  rdt_sts_t   sts_i,
  output logic       in_stall_o,
  output rdt_cmd_t   cmd_o
);

  rdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '{default: '0, osel: OSEL_OFF};
    case (state_q)
      S_IDLE: begin
        in_stall_o = !sts_i.out_free;
        if (in_valid_i && sts_i.out_free) begin
          case (in_op_i)
            OP_ADD: begin
              cmd_o.add_en = 1'b1;
              cmd_o.osel   = sts_i.full ? OSEL_FULL : OSEL_DONE;
            end
            OP_ADV: begin
              cmd_o.adv_en = 1'b1;
              cmd_o.osel   = OSEL_DONE;
            end
            OP_LIST: begin
              if (sts_i.cnt_zero) begin
                cmd_o.osel = OSEL_NOHIT;
              end else begin
                cmd_o.scan_start = 1'b1;
                state_d          = S_READ;
              end
            end
            default: begin
              cmd_o.osel = OSEL_DONE;
            end
          endcase
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHECK;
      end
      S_CHECK: begin
        if (sts_i.hit) begin
          if (!sts_i.pend_vld || sts_i.out_free) begin
            if (sts_i.pend_vld) begin
              cmd_o.osel = OSEL_HIT;
            end
            cmd_o.take_hit = 1'b1;
            if (sts_i.hits_cap || sts_i.scan_last) begin
              state_d = S_FINISH;
            end else begin
              cmd_o.idx_inc = 1'b1;
              state_d       = S_READ;
            end
          end
        end else if (sts_i.scan_last) begin
          state_d = S_FINISH;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_READ;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.osel = sts_i.pend_vld ? OSEL_HIT_LAST : OSEL_NOHIT;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/rdt_dp.sv
// rdt_dp: date registers, reminder memory, scan counters and output register
// depends on rdt_pkg; commanded by rdt_ctrl

module rdt_dp import rdt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MSG_ID_BITS = MSG_ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rdt_in_t               in_data_i,
  input  rdt_cmd_t              cmd_i,
  output rdt_sts_t              sts_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  out_stall_i,
  output logic                  out_valid_o,
  output rdt_out_t              out_data_o
);

  localparam int MsgW  = (MSG_ID_BITS < 16) ? MSG_ID_BITS : 16;
  localparam int CntW  = $clog2(TABLE_DEPTH + 1);
  localparam int IdxW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int MinLo = MsgW;
  localparam int HrLo  = MsgW + 6;
  localparam int DayLo = MsgW + 11;
  localparam int MonLo = MsgW + 16;
  localparam int EntW  = MsgW + 20;

  logic [3:0]      today_month_q, today_month_d;
  logic [4:0]      today_day_q, today_day_d;
  logic [CntW-1:0] count_q;
  logic [IdxW-1:0] idx_q;
  logic [HIT_W-1:0] hits_q;
  logic            pend_vld_q;
  logic [EntW-1:0] pend_q;
  logic [EntW-1:0] rd_q;
  logic [EntW-1:0] mem [TABLE_DEPTH];
  logic            out_vld_q;
  rdt_out_t        out_q, out_d;

  logic            full;
  logic            mem_we;
  logic [EntW-1:0] wr_ent;
  logic [5:0]      day_inc;
  logic [4:0]      mon_inc;
  logic            out_free;
  logic            out_load;
  logic [EntW-1:0] hit_ent;
  logic            show_hit;

  assign full     = count_q == CntW'(TABLE_DEPTH);
  assign mem_we   = cmd_i.add_en && !full;
  assign wr_ent   = {in_data_i.rem_month, in_data_i.rem_day, in_data_i.rem_hour,
                     in_data_i.rem_minute, in_data_i.rem_msg_id[MsgW-1:0]};
  assign out_free = !out_vld_q || !out_stall_i;
  assign out_load = cmd_i.osel != OSEL_OFF;

  // date update
  always_comb begin
    today_month_d = today_month_q;
    today_day_d   = today_day_q;
    day_inc       = {1'b0, today_day_q} + 6'd1;
    mon_inc       = {1'b0, today_month_q} + 5'd1;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_START_MONTH: today_month_d = cfg_wdata_i[3:0];
        CFG_START_DAY:   today_day_d   = cfg_wdata_i[4:0];
        default:         ;
      endcase
    end else if (cmd_i.adv_en) begin
      if (day_inc > {1'b0, days_of(today_month_q)}) begin
        today_day_d   = 5'd1;
        today_month_d = (mon_inc > 5'(MONTHS_PER_YEAR)) ? 4'd1 : mon_inc[3:0];
      end else begin
        today_day_d = day_inc[4:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      today_month_q <= 4'd1;
      today_day_q   <= 5'd1;
      count_q       <= '0;
      idx_q         <= '0;
      hits_q        <= '0;
      pend_vld_q    <= 1'b0;
      out_vld_q     <= 1'b0;
    end else begin
      today_month_q <= today_month_d;
      today_day_q   <= today_day_d;
      if (mem_we) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.scan_start) begin
        idx_q      <= '0;
        hits_q     <= '0;
        pend_vld_q <= 1'b0;
      end else begin
        if (cmd_i.idx_inc) begin
          idx_q <= idx_q + 1'b1;
        end
        if (cmd_i.take_hit) begin
          hits_q     <= hits_q + 1'b1;
          pend_vld_q <= 1'b1;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // reminder memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[count_q[IdxW-1:0]] <= wr_ent;
    end
    if (cmd_i.rd_en) begin
      rd_q <= mem[idx_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_hit) begin
      pend_q <= rd_q;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign hit_ent  = pend_q;
  assign show_hit = (cmd_i.osel == OSEL_HIT) || (cmd_i.osel == OSEL_HIT_LAST);

  always_comb begin
    out_d           = '0;
    out_d.cur_month = today_month_d;
    out_d.cur_day   = today_day_d;
    out_d.last      = cmd_i.osel != OSEL_HIT;
    case (cmd_i.osel)
      OSEL_FULL:                out_d.status = ST_FULL;
      OSEL_NOHIT:               out_d.status = ST_NOHIT;
      OSEL_HIT, OSEL_HIT_LAST:  out_d.status = ST_LISTED;
      default:                  out_d.status = ST_DONE;
    endcase
    if (show_hit) begin
      out_d.out_month  = hit_ent[MonLo+3:MonLo];
      out_d.out_day    = hit_ent[DayLo+4:DayLo];
      out_d.out_hour   = hit_ent[HrLo+4:HrLo];
      out_d.out_minute = hit_ent[MinLo+5:MinLo];
      out_d.out_msg_id = 16'(hit_ent[MsgW-1:0]);
    end
  end

  assign sts_o.out_free  = out_free;
  assign sts_o.full      = full;
  assign sts_o.cnt_zero  = count_q == '0;
  assign sts_o.hit       = (rd_q[MonLo+3:MonLo] == today_month_q) &&
                           (rd_q[DayLo+4:DayLo] == today_day_q);
  assign sts_o.hits_cap  = (hits_q + 1'b1) == HIT_W'(MAX_RESULTS);
  assign sts_o.scan_last = (CntW'(idx_q) + 1'b1) == count_q;
  assign sts_o.pend_vld  = pend_vld_q;

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

### rtl/reminder_day_table.sv
// reminder_day_table: top level of the calendar reminder block
// depends on rdt_pkg, rdt_ctrl and rdt_dp
//
//   channel  | direction | handshake                 | payload
//   input    | in        | in_valid_i / in_stall_o   | in_data_i   (rdt_in_t)
//   output   | out       | out_valid_o / out_stall_i | out_data_o  (rdt_out_t)
//   config   | in        | cfg_we_i                  | cfg_idx_i, cfg_wdata_i
//
// add, advance and unused ops finish in S_IDLE; the result loads the output register
// list reads then compares each stored reminder in S_READ and S_CHECK on one memory port
// a new item is taken only when the output register is empty or being drained
// output stalls hold the scan; reset clears date to 1/1 and the count, no clearing pass

module reminder_day_table import rdt_pkg::*; #(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  parameter int MSG_ID_BITS = MSG_ID_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  rdt_in_t               in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output rdt_out_t              out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  rdt_cmd_t cmd;
  rdt_sts_t sts;

  rdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_op_i    (in_data_i.op),
    .sts_i      (sts),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd)
  );

  rdt_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .MSG_ID_BITS (MSG_ID_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule
